[rtl/core/circular_double_ended_queue_unit_defines.svh]
// Assertion helpers used by the deque RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define CDEQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CDEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cdeq_pkg.sv]
`timescale 1ns / 1ps
package cdeq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // capacity register and entry count widths are fixed by the register map
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_RESP = 2'd2
  } state_t;

endpackage

[rtl/core/cdeq_in_if.sv]
`timescale 1ns / 1ps
interface cdeq_in_if #(
  parameter int DATA_WIDTH = cdeq_pkg::DATA_W_DEF
);
  import cdeq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [DATA_WIDTH-1:0] data_value;

  modport source (output valid, output command, output data_value, input ready);
  modport sink   (input valid, input command, input data_value, output ready);
endinterface

[rtl/core/cdeq_out_if.sv]
`timescale 1ns / 1ps
interface cdeq_out_if #(
  parameter int DATA_WIDTH = cdeq_pkg::DATA_W_DEF
);
  import cdeq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [CAP_W-1:0]      entry_count;
  logic                  empty_flag;
  logic                  full_flag;

  modport source (
    output valid, output status, output front_value, output back_value,
    output entry_count, output empty_flag, output full_flag, input ready
  );
  modport sink (
    input valid, input status, input front_value, input back_value,
    input entry_count, input empty_flag, input full_flag, output ready
  );
endinterface

[rtl/core/cdeq_slot_ram.sv]
`timescale 1ns / 1ps
module cdeq_slot_ram #(
  parameter int DEPTH      = cdeq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdeq_pkg::DATA_W_DEF,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0]      raddr_a,
  input  logic [IDX_W-1:0]      raddr_b,
  output logic [DATA_WIDTH-1:0] rdata_a,
  output logic [DATA_WIDTH-1:0] rdata_b
);
  logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_a_r;
  logic [DATA_WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= slot_mem[raddr_a];
    rd_b_r <= slot_mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;
endmodule

[rtl/core/circular_double_ended_queue_unit.sv]
`timescale 1ns / 1ps
// Ring-buffer deque of signed words, one command per input beat.
// in_ch  : command (push back, push front, pop front, pop back, peek) and the
//          word to insert on a push.
// out_ch : one result beat per command: status, front and back words (zero
//          when empty), entry count, empty and full flags after the command.
// cfg_*  : capacity register; a write also empties the deque. Zero acts as
//          one, values above DEPTH act as DEPTH. Write only while idle.
// Timing : a command is taken in the idle state, its push lands in the slot
//          RAM at that edge, the read state reads front and back through the
//          RAM's two registered read ports, and the result beat is shown in
//          the response state. One command is in flight at a time, so the
//          next command is taken only after the result beat is accepted.
// Reset  : synchronous, active low; the deque empties and the capacity
//          returns to 16 (limited to DEPTH). Slot contents are not cleared.
// Stall  : while out_ch.ready is low the result beat holds and in_ch.ready
//          stays low.
module circular_double_ended_queue_unit #(
  parameter int DEPTH      = cdeq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdeq_pkg::DATA_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cdeq_in_if.sink                    in_ch,
  cdeq_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [cdeq_pkg::CAP_W-1:0] cfg_wdata
);
  import cdeq_pkg::*;

  `include "circular_double_ended_queue_unit_defines.svh"

  localparam int IDX_W = $clog2(DEPTH);
  // arithmetic width wide enough for any index, any capacity and DEPTH itself
  localparam int AW    = (IDX_W > CAP_W) ? IDX_W : CAP_W;
  localparam logic [AW:0] DEPTH_AW = (AW + 1)'(DEPTH);
  localparam logic [AW:0] RESET_AW = (AW + 1)'(CAP_RESET);
  localparam logic [CAP_W-1:0] CAP_INIT =
    (RESET_AW > DEPTH_AW) ? DEPTH_AW[CAP_W-1:0] : RESET_AW[CAP_W-1:0];

  // wrap forward at the capacity
  function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] i,
                                                 logic [CAP_W-1:0] c);
    logic [AW:0] inc;
    inc = {{(AW + 1 - IDX_W){1'b0}}, i} + (AW + 1)'(1);
    if (inc >= {{(AW + 1 - CAP_W){1'b0}}, c}) begin
      return '0;
    end
    return inc[IDX_W-1:0];
  endfunction

  // wrap backward to capacity - 1
  function automatic logic [IDX_W-1:0] ring_prev(logic [IDX_W-1:0] i,
                                                 logic [CAP_W-1:0] c);
    logic [AW:0] dec;
    dec = {{(AW + 1 - CAP_W){1'b0}}, c} - (AW + 1)'(1);
    if (i == '0) begin
      return dec[IDX_W-1:0];
    end
    return i - IDX_W'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [IDX_W-1:0]  back_idx_r, back_idx_nxt;
  logic [CAP_W-1:0]  occ_r, occ_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  status_t           status_r, status_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] front_rd;
  logic [DATA_WIDTH-1:0] back_rd;
  logic                  is_empty;
  logic [AW:0]           cfg_aw;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign is_empty = (occ_r == '0);
  assign cfg_aw   = {{(AW + 1 - CAP_W){1'b0}}, cfg_wdata};

  // command decode: update indices and count, pick the slot to write
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    cap_nxt      = cap_r;
    status_nxt   = status_r;
    back_idx_nxt = back_idx_r;
    ram_we       = 1'b0;
    ram_waddr    = tail_r;
    if (in_fire) begin
      status_nxt = STAT_DONE;
      case (in_ch.command)
        CMD_PUSH_BACK: begin
          if (occ_r >= cap_r) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            tail_nxt  = ring_next(tail_r, cap_r);
            occ_nxt   = occ_r + CAP_W'(1);
          end
        end
        CMD_PUSH_FRONT: begin
          if (occ_r >= cap_r) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ring_prev(head_r, cap_r);
            head_nxt  = ring_prev(head_r, cap_r);
            occ_nxt   = occ_r + CAP_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            head_nxt = ring_next(head_r, cap_r);
            occ_nxt  = occ_r - CAP_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            tail_nxt = ring_prev(tail_r, cap_r);
            occ_nxt  = occ_r - CAP_W'(1);
          end
        end
        default: begin
          // peek and the unused codes leave the state alone
        end
      endcase
      back_idx_nxt = ring_prev(tail_nxt, cap_r);
    end
    // capacity write: map zero to one, saturate at DEPTH and empty the deque
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CAP_W'(1);
      end else if (cfg_aw > DEPTH_AW) begin
        cap_nxt = DEPTH_AW[CAP_W-1:0];
      end else begin
        cap_nxt = cfg_wdata;
      end
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_RESP: begin
        out_ch.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      cap_r      <= CAP_INIT;
      status_r   <= STAT_DONE;
      back_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      occ_r      <= occ_nxt;
      cap_r      <= cap_nxt;
      status_r   <= status_nxt;
      back_idx_r <= back_idx_nxt;
    end
  end

  // push lands at the accept edge; front and back are read the cycle after
  cdeq_slot_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_ch.data_value),
    .raddr_a (head_r),
    .raddr_b (back_idx_r),
    .rdata_a (front_rd),
    .rdata_b (back_rd)
  );

  // result beat: zero the words when nothing is stored
  assign out_ch.status      = status_r;
  assign out_ch.front_value = is_empty ? '0 : front_rd;
  assign out_ch.back_value  = is_empty ? '0 : back_rd;
  assign out_ch.entry_count = occ_r;
  assign out_ch.empty_flag  = is_empty;
  assign out_ch.full_flag   = (occ_r == cap_r);

  `CDEQ_ASSERT(a_occ_bound, clk, rst_n, (occ_r <= cap_r), "occupancy above capacity")
  `CDEQ_ASSERT(a_idx_bound, clk, rst_n, ((head_r < cap_r) && (tail_r < cap_r)), "index out of ring")
  `CDEQ_ASSERT(a_result_follows, clk, rst_n, (in_fire |-> ##2 out_ch.valid), "result beat missing")
  `CDEQ_ASSERT(a_reject_holds, clk, rst_n, ((state_r == ST_READ && status_r != STAT_DONE) |-> (occ_r == $past(occ_r))), "rejected command changed count")
  `CDEQ_ASSERT_ALWAYS(a_one_in_flight, clk, (out_ch.valid |-> !in_ch.ready), "input taken while result pending")
endmodule
